[src/tcbs_pkg.sv]
`default_nettype none
package tcbs_pkg;

	localparam int MAX_POINTS = 64;
	localparam int PT_AW      = $clog2(MAX_POINTS);
	localparam int CNT_W      = 7;
	localparam int FRAC_BITS  = 16;
	localparam int DIV_W      = 48;
	localparam int QS_W       = 26;
	localparam int DIV_STEPS  = DIV_W;

	localparam logic [31:0] CYC_MIN = 32'(64'd1 << (FRAC_BITS - 2));
	localparam logic [31:0] CYC_RST = 32'(64'd5 << FRAC_BITS);
	localparam logic signed [19:0] ONE_F = 20'(64'd1 << FRAC_BITS);
	localparam logic signed [63:0] SAT_LIM = 64'sh3FFF_FFFF_FFFF_FFFF;

	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_EVAL = 1'b1;

	typedef enum logic [2:0] {
		REG_TENSION, REG_BIAS, REG_CONT, REG_CLOSED, REG_COUNT, REG_CYCLE
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_DIV, ST_READ, ST_MUL, ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		MS_IDLE, MS_LO, MS_HI, MS_FIN
	} mul_state_t;

	typedef enum logic [3:0] {
		OP_P0A, OP_P1A, OP_TA, OP_R0, OP_P0B, OP_P1B, OP_TB, OP_R1,
		OP_C2X, OP_C2, OP_C3, OP_H3, OP_H2, OP_H1
	} uop_t;

	typedef struct packed {
		logic              mode;
		logic [5:0]        point_index;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic [31:0]       time_value;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} result_t;

	typedef struct packed {
		logic              start;
		logic signed [63:0] a;
		logic signed [19:0] b;
		logic [4:0]        sh;
	} mul_req_t;

	typedef struct packed {
		logic              done;
		logic signed [63:0] res;
	} mul_rsp_t;

	function automatic logic signed [63:0] sadd(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		s = $signed({a[63], a}) + $signed({b[63], b});
		if (s > $signed({1'b0, SAT_LIM}))
			return SAT_LIM;
		else if (s < -$signed({1'b0, SAT_LIM}))
			return -SAT_LIM;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sx32(input logic signed [31:0] v);
		return {{32{v[31]}}, v};
	endfunction

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (v < -64'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [PT_AW-1:0] prev_idx(input logic [PT_AW-1:0] j,
		input logic [CNT_W-1:0] n, input logic closed);
		if (j == '0)
			return closed ? PT_AW'(n - CNT_W'(1)) : '0;
		return j - PT_AW'(1);
	endfunction

	function automatic logic [PT_AW-1:0] next_idx(input logic [PT_AW-1:0] j,
		input logic [CNT_W-1:0] n, input logic closed);
		if (CNT_W'(j) == n - CNT_W'(1))
			return closed ? '0 : j;
		return j + PT_AW'(1);
	endfunction

endpackage
`default_nettype wire

[src/tcb_spline_evaluator.sv]
`default_nettype none
// TCB spline evaluator.
// Items enter on item_valid/item_stall; a beat is taken when item_valid is high
// and item_stall low. A load item (mode 0) writes one control point into the
// point memories in its accept cycle and gives no result. An evaluate item
// (mode 1) gives exactly one result beat on result_valid/result_stall.
// Configuration is written through the APB port (registers at 4*index).
// An evaluate item runs three passes of a 48-step restoring divider (segment,
// fraction, segment wrap), reads its points from the single-port memories,
// runs 42 operations of one shared multiplier (three axes of 14 operations),
// and then registers the result. With fewer than two points the evaluator
// goes straight to the done state and offers a zero result beat.
// item_stall is high from an evaluate accept until its result is registered,
// so no new item is taken before the previous evaluate result is registered.
// The result register holds while result_stall is high; a finished result
// waits in the block until the register frees, and the input stays stalled.
// Reset restores default registers; point memories hold garbage until loaded.
module tcb_spline_evaluator
	import tcbs_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire item_t       item,
	output logic             result_valid,
	input  wire logic        result_stall,
	output result_t          result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);
	logic [17:0]      tension_q, bias_q, cont_q;
	logic             closed_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      cyc_q;

	state_t state_q, state_nxt;
	logic [1:0] run_q;
	logic [5:0] step_q;
	logic [2:0] rd_q;
	uop_t       op_q;
	logic [1:0] axis_q;
	logic       wait_q;
	logic       result_valid_q;

	logic [DIV_W-1:0] div_q;
	logic [31:0]      rem_q;
	logic [QS_W-1:0]  qsave_q;
	logic [15:0]      u_q;
	logic [PT_AW-1:0] seg_q;
	logic signed [31:0] v_q [3][6];
	logic signed [63:0] p0_q, p1_q, t_q, r0_q, r1_q, c2_q, c3_q, acc_q;
	logic signed [31:0] pos_q [3];
	result_t result_q;

	logic [CNT_W-1:0] n_w;
	logic [38:0]      num_w;
	logic [31:0]      dsr;
	logic [32:0]      trial;
	logic             ge;
	logic [32:0]      rem_nxt;
	logic [PT_AW-1:0] j2, rd_idx, ram_addr;
	logic             ram_we;
	logic [31:0]      rx, ry, rz;
	logic signed [19:0] bias20, cont20, mt;
	logic signed [31:0] v0, v1, v2, v3, v4, v5;
	logic             accept_w, cfg_wr;
	mul_req_t         mul_req;
	mul_rsp_t         mul_rsp;

	assign n_w      = (count_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : count_q;
	assign num_w    = 39'(item.time_value) * 39'(n_w);
	assign accept_w = item_valid && !item_stall;
	assign cfg_wr   = psel && penable && pwrite;
	assign pready   = 1'b1;

	always_comb begin
		case (paddr[4:2])
			REG_TENSION: prdata = {14'd0, tension_q};
			REG_BIAS:    prdata = {14'd0, bias_q};
			REG_CONT:    prdata = {14'd0, cont_q};
			REG_CLOSED:  prdata = {31'd0, closed_q};
			REG_COUNT:   prdata = {25'd0, count_q};
			REG_CYCLE:   prdata = cyc_q;
			default:     prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tension_q <= '0;
			bias_q    <= '0;
			cont_q    <= '0;
			closed_q  <= 1'b0;
			count_q   <= '0;
			cyc_q     <= CYC_RST;
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_TENSION: tension_q <= pwdata[17:0];
				REG_BIAS:    bias_q    <= pwdata[17:0];
				REG_CONT:    cont_q    <= pwdata[17:0];
				REG_CLOSED:  closed_q  <= pwdata[0];
				REG_COUNT:   count_q   <= pwdata[CNT_W-1:0];
				REG_CYCLE:   cyc_q     <= (pwdata < CYC_MIN) ? CYC_MIN : pwdata;
				default: ;
			endcase
		end
	end

	// Divider: one quotient bit a cycle; the third pass reduces the segment modulo n.
	assign dsr     = (run_q == 2'd2) ? {25'd0, n_w} : cyc_q;
	assign trial   = {rem_q, div_q[DIV_W-1]};
	assign ge      = trial >= {1'b0, dsr};
	assign rem_nxt = ge ? (trial - {1'b0, dsr}) : trial;

	assign j2 = (CNT_W'(seg_q) == n_w - CNT_W'(1)) ? '0 : seg_q + PT_AW'(1);

	always_comb begin
		case (rd_q)
			3'd0:    rd_idx = prev_idx(seg_q, n_w, closed_q);
			3'd1:    rd_idx = seg_q;
			3'd2:    rd_idx = next_idx(seg_q, n_w, closed_q);
			3'd3:    rd_idx = prev_idx(j2, n_w, closed_q);
			3'd4:    rd_idx = j2;
			default: rd_idx = next_idx(j2, n_w, closed_q);
		endcase
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE:
				if (item_valid && item.mode == MODE_EVAL)
					state_nxt = (n_w < CNT_W'(2)) ? ST_DONE : ST_DIV;
			ST_DIV:
				if (step_q == 6'(DIV_STEPS) && run_q == 2'd2)
					state_nxt = ST_READ;
			ST_READ:
				if (rd_q == 3'd6)
					state_nxt = ST_MUL;
			ST_MUL:
				if (mul_rsp.done && op_q == OP_H1 && axis_q == 2'd2)
					state_nxt = ST_DONE;
			ST_DONE:
				if (!result_valid_q || !result_stall)
					state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		item_stall    = (state_q != ST_IDLE);
		ram_we        = (state_q == ST_IDLE) && item_valid && item.mode == MODE_LOAD;
		ram_addr      = (state_q == ST_IDLE) ? item.point_index[PT_AW-1:0] : rd_idx;
		mul_req.start = (state_q == ST_MUL) && !wait_q;
		result_valid  = result_valid_q;
		result        = result_q;
	end

	tcbs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(item.point_x), .rdata(rx)
	);
	tcbs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(item.point_y), .rdata(ry)
	);
	tcbs_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_z (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(item.point_z), .rdata(rz)
	);

	assign bias20 = {{2{bias_q[17]}}, bias_q};
	assign cont20 = {{2{cont_q[17]}}, cont_q};
	assign mt     = ONE_F - {{2{tension_q[17]}}, tension_q};
	assign v0 = v_q[axis_q][0];
	assign v1 = v_q[axis_q][1];
	assign v2 = v_q[axis_q][2];
	assign v3 = v_q[axis_q][3];
	assign v4 = v_q[axis_q][4];
	assign v5 = v_q[axis_q][5];

	// Operand selection for the shared multiplier, one micro-op at a time.
	always_comb begin
		mul_req.a  = '0;
		mul_req.b  = '0;
		mul_req.sh = 5'(FRAC_BITS);
		case (op_q)
			OP_P0A: begin
				mul_req.a = sx32(v1) - sx32(v0);
				mul_req.b = ONE_F + bias20;
			end
			OP_P1A: begin
				mul_req.a = sx32(v2) - sx32(v1);
				mul_req.b = ONE_F - bias20;
			end
			OP_TA: begin
				mul_req.a  = sadd(p1_q, -p0_q);
				mul_req.b  = ONE_F + cont20;
				mul_req.sh = 5'(FRAC_BITS + 1);
			end
			OP_R0, OP_R1: begin
				mul_req.a = sadd(p0_q, t_q);
				mul_req.b = mt;
			end
			OP_P0B: begin
				mul_req.a = sx32(v4) - sx32(v3);
				mul_req.b = ONE_F + bias20;
			end
			OP_P1B: begin
				mul_req.a = sx32(v5) - sx32(v4);
				mul_req.b = ONE_F - bias20;
			end
			OP_TB: begin
				mul_req.a  = sadd(p1_q, -p0_q);
				mul_req.b  = ONE_F - cont20;
				mul_req.sh = 5'(FRAC_BITS + 1);
			end
			OP_C2X: begin
				mul_req.a  = sx32(v2) - sx32(v1);
				mul_req.b  = 20'sd3;
				mul_req.sh = '0;
			end
			OP_C2: begin
				mul_req.a  = r0_q;
				mul_req.b  = -20'sd2;
				mul_req.sh = '0;
			end
			OP_C3: begin
				mul_req.a  = sx32(v1) - sx32(v2);
				mul_req.b  = 20'sd2;
				mul_req.sh = '0;
			end
			OP_H3: begin
				mul_req.a = c3_q;
				mul_req.b = {4'd0, u_q};
			end
			OP_H2, OP_H1: begin
				mul_req.a = acc_q;
				mul_req.b = {4'd0, u_q};
			end
			default: ;
		endcase
	end

	tcbs_mul u_mul (
		.clk(clk), .arst_n(arst_n), .req(mul_req), .rsp(mul_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			run_q          <= '0;
			step_q         <= '0;
			rd_q           <= '0;
			op_q           <= OP_P0A;
			axis_q         <= '0;
			wait_q         <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			case (state_q)
				ST_IDLE: begin
					run_q  <= '0;
					step_q <= '0;
					rd_q   <= '0;
					op_q   <= OP_P0A;
					axis_q <= '0;
					wait_q <= 1'b0;
				end
				ST_DIV:
					if (step_q == 6'(DIV_STEPS)) begin
						step_q <= '0;
						run_q  <= run_q + 2'd1;
					end else begin
						step_q <= step_q + 6'd1;
					end
				ST_READ: rd_q <= rd_q + 3'd1;
				ST_MUL:
					if (mul_req.start) begin
						wait_q <= 1'b1;
					end else if (mul_rsp.done) begin
						wait_q <= 1'b0;
						if (op_q == OP_H1) begin
							op_q   <= OP_P0A;
							axis_q <= axis_q + 2'd1;
						end else begin
							op_q <= uop_t'(op_q + 4'd1);
						end
					end
				default: ;
			endcase
			if (state_q == ST_DONE && (!result_valid_q || !result_stall))
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE:
				if (accept_w && item.mode == MODE_EVAL) begin
					div_q <= {9'd0, num_w};
					rem_q <= '0;
					pos_q <= '{default: '0};
				end
			ST_DIV:
				if (step_q != 6'(DIV_STEPS)) begin
					rem_q <= rem_nxt[31:0];
					div_q <= {div_q[DIV_W-2:0], ge};
				end else begin
					rem_q <= '0;
					case (run_q)
						2'd0: begin
							qsave_q <= div_q[QS_W-1:0];
							div_q   <= {rem_q, 16'd0};
						end
						2'd1: begin
							u_q   <= div_q[15:0];
							div_q <= {22'd0, qsave_q};
						end
						default: seg_q <= rem_q[PT_AW-1:0];
					endcase
				end
			ST_READ:
				if (rd_q != 3'd0) begin
					v_q[0][rd_q - 3'd1] <= rx;
					v_q[1][rd_q - 3'd1] <= ry;
					v_q[2][rd_q - 3'd1] <= rz;
				end
			ST_MUL:
				if (mul_rsp.done) begin
					case (op_q)
						OP_P0A, OP_P0B: p0_q <= mul_rsp.res;
						OP_P1A, OP_P1B: p1_q <= mul_rsp.res;
						OP_TA, OP_TB, OP_C2X: t_q <= mul_rsp.res;
						OP_R0: r0_q <= mul_rsp.res;
						OP_R1: r1_q <= mul_rsp.res;
						OP_C2: c2_q <= sadd(sadd(t_q, mul_rsp.res), -r1_q);
						OP_C3: c3_q <= sadd(sadd(mul_rsp.res, r0_q), r1_q);
						OP_H3: acc_q <= sadd(mul_rsp.res, c2_q);
						OP_H2: acc_q <= sadd(mul_rsp.res, r0_q);
						OP_H1: pos_q[axis_q] <= clamp32(sadd(mul_rsp.res, sx32(v1)));
						default: ;
					endcase
				end
			ST_DONE:
				if (!result_valid_q || !result_stall) begin
					result_q.pos_x <= pos_q[0];
					result_q.pos_y <= pos_q[1];
					result_q.pos_z <= pos_q[2];
				end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[src/tcbs_ram.sv]
`default_nettype none
module tcbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule
`default_nettype wire

[src/tcbs_mul.sv]
`default_nettype none
module tcbs_mul
	import tcbs_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mul_req_t req,
	output mul_rsp_t      rsp
);
	mul_state_t state_q, state_nxt;
	logic [63:0] ua_q;
	logic [19:0] ub_q;
	logic        neg_q;
	logic [4:0]  sh_q;
	logic [83:0] full_q;
	logic [51:0] pp;
	logic [83:0] rnd;
	logic [83:0] shifted;
	logic [63:0] mag;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			MS_IDLE: if (req.start) state_nxt = MS_LO;
			MS_LO:   state_nxt = MS_HI;
			MS_HI:   state_nxt = MS_FIN;
			MS_FIN:  state_nxt = MS_IDLE;
			default: state_nxt = MS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= MS_IDLE;
		else
			state_q <= state_nxt;
	end

	assign pp = {20'd0, (state_q == MS_HI) ? ua_q[63:32] : ua_q[31:0]} * {32'd0, ub_q};

	// Magnitudes are multiplied in two 32-bit halves, then rounded half away from zero.
	always_ff @(posedge clk) begin
		case (state_q)
			MS_IDLE: begin
				ua_q  <= req.a[63] ? (~req.a + 64'd1) : req.a;
				ub_q  <= req.b[19] ? (~req.b + 20'd1) : req.b;
				neg_q <= req.a[63] ^ req.b[19];
				sh_q  <= req.sh;
			end
			MS_LO: full_q <= {32'd0, pp};
			MS_HI: full_q <= full_q + {pp, 32'd0};
			default: ;
		endcase
	end

	always_comb begin
		rnd     = full_q + ((84'd1 << sh_q) >> 1);
		shifted = rnd >> sh_q;
		mag     = (shifted > 84'(SAT_LIM)) ? SAT_LIM : shifted[63:0];
		rsp.done = (state_q == MS_FIN);
		rsp.res  = neg_q ? -$signed(mag) : $signed(mag);
	end
endmodule
`default_nettype wire

[src/tcbs_checker.sv]
`default_nettype none
module tcbs_checker
	import tcbs_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);
	// A result beat that is held back must stay offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> $stable(result))
		else $error("stalled result beat changed");

	// An evaluate beat keeps the input side closed while the item is worked on.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.mode == MODE_EVAL |=> item_stall)
		else $error("input open right after an evaluate beat");

	// A load beat never produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.mode == MODE_LOAD && !result_valid
		|=> !result_valid)
		else $error("result appeared after a load beat");
endmodule

bind tcb_spline_evaluator tcbs_checker u_tcbs_checker (.*);
`default_nettype wire
